// ----- rtl/pack_object_header_parser_macros.svh -----
// Assertion macros used by the packed-object header parser checker.
`ifndef PACK_OBJECT_HEADER_PARSER_MACROS_SVH
`define PACK_OBJECT_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define POHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define POHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pohp_pkg.sv -----
// Types, codes and defaults for the packed-object header parser.
`timescale 1ns / 1ps
`default_nettype none

package pohp_pkg;

  localparam int POS_W          = 40;
  localparam int OBJ_SIZE_W     = 40;
  localparam int HDR_LEN_W      = 5;

  localparam int OFFSET_BITS_DEF = 40;
  localparam int SIZE_BITS_DEF   = 40;
  localparam int ID_BYTES_DEF    = 20;

  localparam logic [HDR_LEN_W-1:0] HDR_LEN_MAX = 5'd31;
  localparam logic [5:0]           SHIFT_MAX   = 6'd63;
  localparam logic [5:0]           SHIFT_FIRST = 6'd4;

  // Object type codes from bits 6..4 of the first header byte.
  localparam logic [2:0] TYP_PLAIN_1   = 3'd1;
  localparam logic [2:0] TYP_PLAIN_2   = 3'd2;
  localparam logic [2:0] TYP_PLAIN_3   = 3'd3;
  localparam logic [2:0] TYP_PLAIN_4   = 3'd4;
  localparam logic [2:0] TYP_OFS_DELTA = 3'd6;
  localparam logic [2:0] TYP_REF_DELTA = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd1;
  localparam logic [2:0] ST_OFS_OVF   = 3'd2;
  localparam logic [2:0] ST_OFS_BOUND = 3'd3;
  localparam logic [2:0] ST_SIZE_LONG = 3'd4;

  localparam logic KIND_SUMMARY = 1'b0;
  localparam logic KIND_ID      = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIZE,
    PH_OFFSET,
    PH_ID
  } phase_t;

  typedef struct packed {
    logic [7:0]       hdr_byte;
    logic             start_req;
    logic [POS_W-1:0] object_pos;
  } in_item_t;

  typedef struct packed {
    logic                  kind;
    logic [2:0]            obj_type;
    logic [OBJ_SIZE_W-1:0] obj_size;
    logic [POS_W-1:0]      base_pos;
    logic [7:0]            id_byte;
    logic [HDR_LEN_W-1:0]  header_len;
    logic [2:0]            status;
    logic                  last;
  } out_item_t;

  // Result of one header byte, handed from the decoder to the output stage.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

`default_nettype wire

// ----- rtl/pohp_core.sv -----
// Header decoder: parse state and the per-byte next-state and result logic.
`timescale 1ns / 1ps
`default_nettype none

module pohp_core import pohp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF,
  parameter int ID_BYTES    = ID_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step_en,
  input  wire in_item_t  item,
  output step_res_t      res
);

  localparam int SW    = SIZE_BITS;
  localparam int OW    = OFFSET_BITS;
  localparam int CW    = (OW > POS_W) ? OW : POS_W;
  localparam int IDC_W = $clog2(ID_BYTES + 1);

  phase_t               phase_r, phase_nxt;
  logic [2:0]           type_r, type_nxt;
  logic [SW-1:0]        size_r, size_nxt;
  logic [5:0]           shift_r, shift_nxt;
  logic [OW-1:0]        ofs_r, ofs_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [HDR_LEN_W-1:0] bcnt_r, bcnt_nxt;
  logic [IDC_W-1:0]     idc_r, idc_nxt;

  logic [HDR_LEN_W-1:0] bcnt_sat;
  logic [SW-1:0]        size_add;
  logic                 size_full;
  logic [6:0]           shift_sum;
  logic [5:0]           shift_sat;
  logic [OW-1:0]        ofs_acc;
  logic [OW-1:0]        ofs_inc;
  logic                 ofs_ovf;
  logic [CW-1:0]        ofs_cmp;
  logic                 ofs_bad;
  logic [IDC_W-1:0]     idc_inc;
  logic                 size_done;

  always_comb begin
    bcnt_sat  = (bcnt_r == HDR_LEN_MAX) ? bcnt_r : bcnt_r + 5'd1;
    size_add  = {{(SW-7){1'b0}}, item.hdr_byte[6:0]} << shift_r;
    size_full = ({1'b0, shift_r} >= 7'(SIZE_BITS)) || (shift_r == SHIFT_MAX);
    shift_sum = {1'b0, shift_r} + 7'd7;
    shift_sat = shift_sum[6] ? SHIFT_MAX : shift_sum[5:0];
    ofs_acc   = {ofs_r[OW-8:0], item.hdr_byte[6:0]};
    ofs_inc   = ofs_acc + {{(OW-1){1'b0}}, 1'b1};
    ofs_ovf   = (ofs_inc == '0) || (ofs_inc[OW-1 -: 7] != 7'd0);
    ofs_cmp   = CW'(ofs_acc);
    ofs_bad   = (ofs_acc == '0) || (ofs_cmp >= CW'(pos_r));
    idc_inc   = idc_r + {{(IDC_W-1){1'b0}}, 1'b1};
  end

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    size_nxt  = size_r;
    shift_nxt = shift_r;
    ofs_nxt   = ofs_r;
    pos_nxt   = pos_r;
    bcnt_nxt  = bcnt_r;
    idc_nxt   = idc_r;
    size_done = 1'b0;

    res.valid           = 1'b0;
    res.item.kind       = KIND_SUMMARY;
    res.item.status     = ST_OK;
    res.item.last       = 1'b0;
    res.item.base_pos   = '0;
    res.item.id_byte    = 8'd0;

    if (item.start_req) begin
      // A start byte abandons whatever object was in flight.
      pos_nxt   = item.object_pos;
      type_nxt  = item.hdr_byte[6:4];
      size_nxt  = {{(SW-4){1'b0}}, item.hdr_byte[3:0]};
      shift_nxt = SHIFT_FIRST;
      bcnt_nxt  = 5'd1;
      ofs_nxt   = '0;
      idc_nxt   = '0;
      if (item.hdr_byte[7]) begin
        phase_nxt = PH_SIZE;
      end else begin
        size_done = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_SIZE: begin
          bcnt_nxt = bcnt_sat;
          if (size_full) begin
            phase_nxt       = PH_IDLE;
            res.valid       = 1'b1;
            res.item.status = ST_SIZE_LONG;
            res.item.last   = 1'b1;
          end else begin
            size_nxt  = size_r + size_add;
            shift_nxt = shift_sat;
            if (!item.hdr_byte[7]) begin
              size_done = 1'b1;
            end
          end
        end
        PH_OFFSET: begin
          bcnt_nxt = bcnt_sat;
          if (item.hdr_byte[7]) begin
            if (ofs_ovf) begin
              phase_nxt       = PH_IDLE;
              res.valid       = 1'b1;
              res.item.status = ST_OFS_OVF;
              res.item.last   = 1'b1;
            end else begin
              ofs_nxt = ofs_inc;
            end
          end else begin
            phase_nxt     = PH_IDLE;
            res.valid     = 1'b1;
            res.item.last = 1'b1;
            if (ofs_bad) begin
              res.item.status = ST_OFS_BOUND;
            end else begin
              res.item.base_pos = pos_r - ofs_cmp[POS_W-1:0];
            end
          end
        end
        PH_ID: begin
          bcnt_nxt         = bcnt_sat;
          idc_nxt          = idc_inc;
          res.valid        = 1'b1;
          res.item.kind    = KIND_ID;
          res.item.id_byte = item.hdr_byte;
          res.item.last    = (idc_inc >= IDC_W'(ID_BYTES));
          if (res.item.last) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          // drop stray bytes while idle
        end
      endcase
    end

    if (size_done) begin
      case (type_nxt)
        TYP_PLAIN_1, TYP_PLAIN_2, TYP_PLAIN_3, TYP_PLAIN_4: begin
          phase_nxt     = PH_IDLE;
          res.valid     = 1'b1;
          res.item.last = 1'b1;
        end
        TYP_OFS_DELTA: begin
          phase_nxt = PH_OFFSET;
          ofs_nxt   = '0;
        end
        TYP_REF_DELTA: begin
          phase_nxt = PH_ID;
          idc_nxt   = '0;
        end
        default: begin
          phase_nxt       = PH_IDLE;
          res.valid       = 1'b1;
          res.item.status = ST_BAD_TYPE;
          res.item.last   = 1'b1;
        end
      endcase
    end

    res.item.obj_type   = type_nxt;
    res.item.obj_size   = OBJ_SIZE_W'(size_nxt);
    res.item.header_len = bcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      type_r  <= 3'd0;
      size_r  <= '0;
      shift_r <= 6'd0;
      ofs_r   <= '0;
      pos_r   <= '0;
      bcnt_r  <= '0;
      idc_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      size_r  <= size_nxt;
      shift_r <= shift_nxt;
      ofs_r   <= ofs_nxt;
      pos_r   <= pos_nxt;
      bcnt_r  <= bcnt_nxt;
      idc_r   <= idc_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pack_object_header_parser.sv -----
// Packed-object header parser: one header byte per cycle in while no result stalls, at most one result out.
// A byte is held in the input register; its result, if any, is then registered in the result register.
// Throughput: one byte per cycle through a single-pass decode; a byte that yields a
// result waits in the input register, with in_ready low, while an earlier result stalls.
// Reset (rst_n low, synchronous) empties both registers and returns the parser to idle.
`timescale 1ns / 1ps
`default_nettype none

module pack_object_header_parser import pohp_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int SIZE_BITS   = SIZE_BITS_DEF,
  parameter int ID_BYTES    = ID_BYTES_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic      s1_v_r, s1_v_nxt;
  in_item_t  s1_item_r;
  logic      out_v_r, out_v_nxt;
  out_item_t out_item_r;
  step_res_t step_res;
  logic      fire;

  pohp_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .SIZE_BITS   (SIZE_BITS),
    .ID_BYTES    (ID_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (s1_item_r),
    .res     (step_res)
  );

  // Advance the held byte unless it has a result and the output is stalled.
  always_comb begin
    fire      = s1_v_r && (!step_res.valid || !out_v_r || out_ready);
    in_ready  = !s1_v_r || fire;
    s1_v_nxt  = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : s1_v_r);
    out_v_nxt = (fire && step_res.valid) ? 1'b1 : (out_ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
    if (fire && step_res.valid) begin
      out_item_r <= step_res.item;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ----- rtl/pohp_checker.sv -----
// Port-level checks on the parser's result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "pack_object_header_parser_macros.svh"

module pohp_checker import pohp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  `POHP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")
  `POHP_ASSERT_NOW(a_id_ok, out_valid && (out_item.kind == KIND_ID), out_item.status == ST_OK, "identifier byte carries an error status")
  `POHP_ASSERT_NOW(a_err_ends, out_valid && (out_item.status != ST_OK), out_item.last && (out_item.base_pos == '0) && (out_item.id_byte == 8'd0), "error result does not end the header cleanly")
  `POHP_ASSERT_NOW(a_len_nz, out_valid, out_item.header_len != '0, "result with zero header length")

endmodule

bind pack_object_header_parser pohp_checker u_pohp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
